>>> hdl/file_delivery_pdu_header_parser_macros.svh
// Assertion helpers used by the checker file.
`ifndef FILE_DELIVERY_PDU_HEADER_PARSER_MACROS_SVH
`define FILE_DELIVERY_PDU_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define FDPH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fdph: implication check failed");

// Next-cycle implication, disabled while reset is low.
`define FDPH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fdph: next-cycle check failed");

`endif

>>> hdl/fdph_pkg.sv
package fdph_pkg;

    typedef logic [4:0] pos_t;
    typedef logic [5:0] span_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_header;
        logic       last_of_input;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  version_number;
        logic [6:0]  control_flags;
        logic [15:0] data_length;
        logic [3:0]  id_byte_count;
        logic [3:0]  sequence_byte_count;
        logic [63:0] source_id;
        logic [63:0] sequence_number;
        logic [63:0] dest_id;
        logic        status;
    } out_item_t;

    // byte positions of the fixed part of the header
    localparam pos_t POS_BYTE0  = 5'd0;
    localparam pos_t POS_LEN_HI = 5'd1;
    localparam pos_t POS_LEN_LO = 5'd2;
    localparam pos_t POS_FLAGS  = 5'd3;

    localparam span_t FIXED_HDR_BYTES = 6'd4;

    localparam int unsigned CRC_FLAG_BIT  = 1;
    localparam logic [15:0] CRC_LEN_BYTES = 16'd4;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_SHORT = 1'b1;

endpackage

>>> hdl/fdph_in_stage.sv
module fdph_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fdph_pkg::in_item_t s_item,
    input  logic               advance,
    output logic               item_valid,
    output fdph_pkg::in_item_t item
);
    import fdph_pkg::*;

    logic     valid_reg, valid_next;
    in_item_t item_reg, item_next;

    // stage frees up in the same cycle it hands its item on
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_ready) begin
            valid_next = s_valid;
            item_next  = s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> hdl/fdph_decoder.sv
module fdph_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  fdph_pkg::in_item_t  item,
    output logic                res_valid,
    output fdph_pkg::out_item_t res
);
    import fdph_pkg::*;

    pos_t        pos_reg, pos_next;
    logic [7:0]  byte0_reg, byte0_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  byte3_reg, byte3_next;
    logic [63:0] src_reg, src_next;
    logic [63:0] seq_reg, seq_next;
    logic [63:0] dst_reg, dst_next;

    pos_t        pos;
    logic [7:0]  byte3_cur;
    logic [3:0]  id_len, seq_len;
    span_t       src_end, seq_end, total;
    logic        done;
    logic [15:0] len_out;

    always_comb begin
        pos        = item.first_of_header ? POS_BYTE0 : pos_reg;
        byte3_cur  = (pos == POS_FLAGS) ? item.data_byte : byte3_reg;
        id_len     = {1'b0, byte3_cur[6:4]} + 4'd1;
        seq_len    = {1'b0, byte3_cur[2:0]} + 4'd1;
        src_end    = FIXED_HDR_BYTES + {2'b00, id_len};
        seq_end    = src_end + {2'b00, seq_len};
        total      = seq_end + {2'b00, id_len};

        byte0_next = byte0_reg;
        len_next   = len_reg;
        byte3_next = byte3_reg;
        src_next   = src_reg;
        seq_next   = seq_reg;
        dst_next   = dst_reg;

        if (pos == POS_BYTE0) begin
            byte0_next = item.data_byte;
            len_next   = '0;
            byte3_next = '0;
            src_next   = '0;
            seq_next   = '0;
            dst_next   = '0;
        end else if (pos inside {POS_LEN_HI, POS_LEN_LO}) begin
            len_next = {len_reg[7:0], item.data_byte};
        end else if (pos == POS_FLAGS) begin
            byte3_next = item.data_byte;
        end else if ({1'b0, pos} < src_end) begin
            src_next = {src_reg[55:0], item.data_byte};
        end else if ({1'b0, pos} < seq_end) begin
            seq_next = {seq_reg[55:0], item.data_byte};
        end else begin
            dst_next = {dst_reg[55:0], item.data_byte};
        end

        done = (pos >= POS_FLAGS) && (({1'b0, pos} + 6'd1) >= total);

        len_out = byte0_next[CRC_FLAG_BIT] ? (len_next - CRC_LEN_BYTES) : len_next;

        if (done || item.last_of_input) begin
            pos_next = POS_BYTE0;
        end else begin
            pos_next = pos + 5'd1;
        end
    end

    // completion wins over end of input; a short header gives all-zero fields with status STATUS_SHORT
    always_comb begin
        res = '0;
        if (done) begin
            res.version_number      = byte0_next[7:5];
            res.control_flags       = {byte0_next[4:0], byte3_next[7], byte3_next[3]};
            res.data_length         = len_out;
            res.id_byte_count       = id_len;
            res.sequence_byte_count = seq_len;
            res.source_id           = src_next;
            res.sequence_number     = seq_next;
            res.dest_id             = dst_next;
            res.status              = STATUS_OK;
        end else begin
            res.status = STATUS_SHORT;
        end
        res_valid = en && (done || item.last_of_input);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_BYTE0;
        end else if (en) begin
            pos_reg <= pos_next;
        end
        if (en) begin
            byte0_reg <= byte0_next;
            len_reg   <= len_next;
            byte3_reg <= byte3_next;
            src_reg   <= src_next;
            seq_reg   <= seq_next;
            dst_reg   <= dst_next;
        end
    end

endmodule

>>> hdl/fdph_out_stage.sv
module fdph_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  fdph_pkg::out_item_t res,
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output fdph_pkg::out_item_t m_item
);
    import fdph_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t item_reg, item_next;

    assign room = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (room) begin
            valid_next = load;
            item_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

>>> hdl/file_delivery_pdu_header_parser.sv
// Channel  Direction  Payload      Handshake
// s_       in         in_item_t    s_valid / s_ready, one header byte per request
// m_       out        out_item_t   m_valid / m_ready, one decoded header or error
//
// One byte per cycle sustained while the m_ side takes results; the byte that ends
// the header passes the input register, then is decoded into the result register.
// Synchronous active-low reset clears the valid flags and the byte position.
// A stalled m_ side holds the pipe; the input register still fills behind it.

module file_delivery_pdu_header_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fdph_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output fdph_pkg::out_item_t m_item
);
    import fdph_pkg::*;

    logic      item_valid;
    in_item_t  item;
    logic      room;
    logic      advance;
    logic      res_valid;
    out_item_t res;

    assign advance = item_valid && room;

    fdph_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    fdph_decoder u_dec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    fdph_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (res_valid),
        .res     (res),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

>>> hdl/fdph_checker.sv
`include "file_delivery_pdu_header_parser_macros.svh"

module fdph_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input fdph_pkg::in_item_t  s_item,
    input logic                m_valid,
    input logic                m_ready,
    input fdph_pkg::out_item_t m_item
);
    import fdph_pkg::*;

    logic in_ok;
    logic is_short;
    logic short_zero;
    logic counts_ok;

    // the input register holds a request only if it was just taken or the input was stalled
    assign in_ok = s_valid || !s_ready;
    assign is_short = (m_item.status == STATUS_SHORT);
    assign short_zero = (m_item.source_id == 64'd0) && (m_item.dest_id == 64'd0)
        && (m_item.sequence_number == 64'd0) && (m_item.id_byte_count == 4'd0)
        && (m_item.data_length == 16'd0) && (m_item.control_flags == 7'd0);
    assign counts_ok = (m_item.id_byte_count != 4'd0) && (m_item.id_byte_count <= 4'd8)
        && (m_item.sequence_byte_count != 4'd0) && (m_item.sequence_byte_count <= 4'd8);

    `FDPH_ASSERT_NXT(a_m_valid_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `FDPH_ASSERT_NXT(a_m_item_hold, aclk, aresetn, m_valid && !m_ready, $stable(m_item))
    `FDPH_ASSERT_IMP(a_short_zero, aclk, aresetn, m_valid && is_short, short_zero)
    `FDPH_ASSERT_IMP(a_counts_range, aclk, aresetn, m_valid && !is_short, counts_ok)
    `FDPH_ASSERT_IMP(a_no_out_from_empty, aclk, aresetn, $rose(m_valid), $past(in_ok, 2))

endmodule

bind file_delivery_pdu_header_parser fdph_checker u_fdph_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
